// ===== src/assert_macros.svh =====
// Shared assertion macros for the channel table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_AT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("channel table assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    `ASSERT_AT_CLK(label, clk, rst_n, (ante) |=> (cons))

`endif

// ===== src/rsct_pkg.sv =====
package rsct_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int COUNT_W             = 5;
    localparam int IN_DATA_W           = 32;
    localparam int OUT_DATA_W          = 24;
    localparam int OUT_PAD_W           = 3;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_SCAN   = 2'd1,
        OP_CHOOSE = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_END   = 2'd2,
        STS_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_UPDATE
    } t_cell_op;

    typedef struct packed {
        logic [7:0]        channel;
        logic signed [7:0] snr;
        logic signed [7:0] rssi;
        logic              synced;
    } t_entry;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic     cmp_en;
        t_cell_op op;
        t_entry   data;
    } t_cell_cmd;

endpackage

// ===== src/rsct_cell.sv =====
module rsct_cell (
    input  logic               i_clk,
    input  rsct_pkg::t_cell_cmd i_cmd,
    input  logic               i_valid,
    input  rsct_pkg::t_entry   i_left,
    input  rsct_pkg::t_entry   i_right,
    input  logic               i_lower_seen,
    input  logic               i_match_seen,
    output logic               o_lower_seen,
    output logic               o_match_seen,
    output rsct_pkg::t_entry   o_entry
);
    import rsct_pkg::*;

    t_entry r_entry;
    logic   r_match;
    logic   r_lower;

    // Flags are sampled in the compare cycle and used in the apply cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_en) begin
            r_match <= i_valid && (r_entry.channel == i_cmd.data.channel);
            r_lower <= i_valid && ($signed(r_entry.rssi) < $signed(i_cmd.data.rssi));
        end
        case (i_cmd.op)
            CELL_INSERT: begin
                // cells past the insertion point shift right by one
                if (i_lower_seen) begin
                    r_entry <= i_left;
                end else if (r_lower || !i_valid) begin
                    r_entry <= i_cmd.data;
                end
            end
            CELL_REMOVE: begin
                if (i_match_seen || r_match) begin
                    r_entry <= i_right;
                end
            end
            CELL_UPDATE: begin
                if (r_match) begin
                    r_entry.snr    <= i_cmd.data.snr;
                    r_entry.rssi   <= i_cmd.data.rssi;
                    r_entry.synced <= i_cmd.data.synced;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_lower_seen = i_lower_seen | r_lower;
    assign o_match_seen = i_match_seen | r_match;
    assign o_entry      = r_entry;

endmodule

// ===== src/rssi_sorted_channel_table_top.sv =====
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: opcode; tdata: channel, snr, rssi, flags
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser: status; tdata: channel, snr, entry count
//
// Each request passes through accept, compare in every cell, shift/update and result.
// The chain of cells is the only storage; one request is in flight at a time.
// Reset (synchronous, i_rst_n low) empties the table and drops any pending result.
// A stalled m_axis holds the finished result; the next request is still accepted and
// processed, then waits in the result stage until the held result is taken.
`include "assert_macros.svh"

module rssi_sorted_channel_table_top #(
    parameter int TABLE_DEPTH = rsct_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] channel, [15:8] snr_in, [23:16] rssi_in, [24] synced, [25] force_keep
    input  logic [rsct_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] chosen_channel, [15:8] chosen_snr, [20:16] entry_count
    output logic [rsct_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]                     m_axis_tuser
);
    import rsct_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY,
        S_PUSH
    } t_state;

    t_state                r_state, n_state;
    t_opcode               r_op, n_op;
    t_entry                r_req, n_req;
    logic                  r_keep, n_keep;
    t_status               r_status, n_status;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_cursor, n_cursor;
    logic                  r_cursor_valid, n_cursor_valid;
    logic [7:0]            r_res_ch, n_res_ch;
    logic [7:0]            r_res_snr, n_res_snr;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [1:0]            r_out_user, n_out_user;

    t_cell_cmd             cell_cmd;
    t_entry                cell_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH:0]  lower_seen;
    logic [TABLE_DEPTH:0]  match_seen;
    logic                  match_any;
    logic [CNT_W-1:0]      cursor_next;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign lower_seen[0] = 1'b0;
    assign match_seen[0] = 1'b0;
    assign match_any     = match_seen[TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_entry left_entry;
        t_entry right_entry;
        logic   cell_valid;

        if (g == 0) begin : g_first
            assign left_entry = cell_cmd.data;
        end else begin : g_inner
            assign left_entry = cell_entry[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_last
            assign right_entry = cell_entry[g];
        end else begin : g_body
            assign right_entry = cell_entry[g+1];
        end
        assign cell_valid = CNT_W'(g) < r_count;

        rsct_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cell_cmd),
            .i_valid      (cell_valid),
            .i_left       (left_entry),
            .i_right      (right_entry),
            .i_lower_seen (lower_seen[g]),
            .i_match_seen (match_seen[g]),
            .o_lower_seen (lower_seen[g+1]),
            .o_match_seen (match_seen[g+1]),
            .o_entry      (cell_entry[g])
        );
    end

    assign cursor_next = CNT_W'(r_cursor) + CNT_W'(1);
    assign count_ext   = {{COUNT_W{1'b0}}, r_count};

    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_req          = r_req;
        n_keep         = r_keep;
        n_status       = r_status;
        n_count        = r_count;
        n_cursor       = r_cursor;
        n_cursor_valid = r_cursor_valid;
        n_res_ch       = r_res_ch;
        n_res_snr      = r_res_snr;
        n_out_valid    = r_out_valid && !m_axis_tready;
        n_out_data     = r_out_data;
        n_out_user     = r_out_user;
        cell_cmd.cmp_en = 1'b0;
        cell_cmd.op     = CELL_HOLD;
        cell_cmd.data   = r_req;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op           = t_opcode'(s_axis_tuser);
                    n_req.channel  = s_axis_tdata[7:0];
                    // force mode keeps rssi in the snr slot
                    n_req.snr      = s_axis_tdata[25] ? s_axis_tdata[23:16]
                                                      : s_axis_tdata[15:8];
                    n_req.rssi     = s_axis_tdata[23:16];
                    n_req.synced   = s_axis_tdata[24];
                    n_keep         = s_axis_tdata[24] | s_axis_tdata[25];
                    n_status       = STS_OK;
                    n_state        = S_CMP;
                end
            end
            S_CMP: begin
                cell_cmd.cmp_en = 1'b1;
                unique case (r_op)
                    OP_CLEAR: begin
                        n_count        = '0;
                        n_cursor       = '0;
                        n_cursor_valid = 1'b0;
                    end
                    OP_CHOOSE: begin
                        if (r_count == '0) begin
                            n_status       = STS_EMPTY;
                            n_cursor_valid = 1'b0;
                        end else if (!r_cursor_valid) begin
                            n_cursor       = '0;
                            n_cursor_valid = 1'b1;
                        end else if (cursor_next >= r_count) begin
                            n_status       = STS_END;
                            n_cursor_valid = 1'b0;
                        end else begin
                            n_cursor = r_cursor + IDX_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
                n_state = S_APPLY;
            end
            S_APPLY: begin
                n_res_ch  = '0;
                n_res_snr = '0;
                unique case (r_op)
                    OP_SCAN: begin
                        if (r_keep) begin
                            if (match_any) begin
                                cell_cmd.op = CELL_UPDATE;
                            end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                n_status = STS_FULL;
                            end else begin
                                cell_cmd.op    = CELL_INSERT;
                                n_count        = r_count + CNT_W'(1);
                                n_cursor_valid = 1'b0;
                            end
                        end else if (match_any) begin
                            cell_cmd.op    = CELL_REMOVE;
                            n_count        = r_count - CNT_W'(1);
                            n_cursor_valid = 1'b0;
                        end
                    end
                    OP_CHOOSE: begin
                        if (r_status == STS_OK) begin
                            n_res_ch  = cell_entry[r_cursor].channel;
                            n_res_snr = cell_entry[r_cursor].snr;
                        end
                    end
                    default: begin
                    end
                endcase
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_user  = r_status;
                    n_out_data  = {{OUT_PAD_W{1'b0}}, count_ext[COUNT_W-1:0],
                                   r_res_snr, r_res_ch};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_req      <= n_req;
        r_keep     <= n_keep;
        r_status   <= n_status;
        r_res_ch   <= n_res_ch;
        r_res_snr  <= n_res_snr;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_cursor       <= '0;
            r_cursor_valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_cursor       <= n_cursor;
            r_cursor_valid <= n_cursor_valid;
            r_out_valid    <= n_out_valid;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    `ASSERT_AT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(TABLE_DEPTH))
    `ASSERT_AT_CLK(a_cursor_in_table, i_clk, i_rst_n, r_cursor_valid |-> (CNT_W'(r_cursor) < r_count))
    `ASSERT_NEXT(a_push_done, i_clk, i_rst_n, r_state == S_PUSH && (!r_out_valid || m_axis_tready), r_out_valid && r_state == S_IDLE)
    `ASSERT_NEXT(a_count_quiet, i_clk, i_rst_n, r_state == S_IDLE || r_state == S_PUSH, r_count == $past(r_count))

endmodule
